@@ src/kts_pkg.sv @@
// ---------------------------------------------------------------------------
// kts_pkg
// Shared types, codes and constants of the keyframe track sampler.
// ---------------------------------------------------------------------------
package kts_pkg;

   localparam int MAX_KEYS_DEF  = 256;
   localparam int FRAC_BITS_DEF = 16;

   localparam int WORD_W     = 32;
   localparam int OP_W       = 2;
   localparam int SLOT_W     = 10;
   localparam int MODE_W     = 2;
   localparam int TCOUNT_W   = 9;
   localparam int VCOUNT_W   = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 96;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 2 * MUL_W;

   localparam logic [OP_W-1:0] OP_WR_TIME  = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_VALUE = 2'd1;
   localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CUBIC = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_COUNT  = 2'd3;

   localparam logic [WORD_W-1:0] NEUTRAL_ONE = 32'h0001_0000;

   typedef enum logic [5:0] {
      S_IDLE, S_DECODE, S_WRITE, S_CHECK, S_FIRST, S_LAST, S_SRCH_A, S_SRCH_B,
      S_SPAN1, S_SPAN2, S_DIVSET, S_DIV, S_T2, S_T3, S_HERM, S_VAL, S_SINGLE,
      S_FALLBACK, S_L1, S_L2, S_LM, S_LA, S_H1, S_H2, S_H3, S_H4, S_HA, S_HB,
      S_HC, S_HD, S_HE, S_HF, S_HG, S_DONE
   } state_type;

   typedef enum logic [5:0] {
      CMD_NONE, CMD_LATCH, CMD_WRITE, CMD_RD_FIRST, CMD_FIRST, CMD_LAST,
      CMD_SRCH_RD, CMD_SRCH_STEP, CMD_SRCH_END, CMD_SPAN_RD1, CMD_SPAN_CAP,
      CMD_DIV_SET, CMD_DIV_STEP, CMD_T2, CMD_T3, CMD_HERM, CMD_VAL_RD,
      CMD_SINGLE, CMD_FALLBACK, CMD_CAP_A, CMD_CAP_B, CMD_CAP_C, CMD_CAP_D,
      CMD_LERP_MUL, CMD_LERP_ADD, CMD_H_A, CMD_H_B, CMD_H_C, CMD_H_D, CMD_H_E,
      CMD_H_F, CMD_H_G, CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            no_data;
      logic            first_hit;
      logic            last_hit;
      logic            srch_more;
      logic            div_needed;
      logic            div_last;
      logic            val_fb;
      logic            val_single;
      logic            val_cubic;
      logic            comp_last;
      logic            rsp_free;
   } status_type;

   function automatic logic [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
      logic [WORD_W-1:0] r;
      if ((&x[PROD_W-1:WORD_W-1]) || ~(|x[PROD_W-1:WORD_W-1])) begin
         r = x[WORD_W-1:0];
      end else if (x[PROD_W-1]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

@@ src/keyframe_track_sampler.sv @@
// ---------------------------------------------------------------------------
// keyframe_track_sampler
// Animation track sampler: key time and xyz value stores, span search,
// fraction divide and step, linear or cubic Hermite interpolation.
// ---------------------------------------------------------------------------
// Writes (op 0, 1) pass through decode to the write state; op 3 is dropped after decode.
// Sample time is set by the search reads of the single-port key memory, the
// one-bit-a-cycle divider and the shared multiplier (seven steps per
// component in cubic mode).
// One transaction at a time; reset clears control and configuration, not stores.
module keyframe_track_sampler #(
   parameter int MAX_KEYS  = kts_pkg::MAX_KEYS_DEF,
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // entry_index[9:0], time_word[41:10], value_x[73:42], value_y[105:74],
   // value_z[137:106]
   input  logic [kts_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [kts_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64]
   output logic [kts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // fell_back[0]
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0] csr_data
);

   kts_pkg::cmd_type    cmd;
   kts_pkg::status_type status;

   assign csr_ready = 1'b1;

   kts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kts_dp #(
      .MAX_KEYS  (MAX_KEYS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

@@ src/kts_ctrl.sv @@
// ---------------------------------------------------------------------------
// kts_ctrl
// Sequencer of the sampler: steps the datapath through writes, the span
// search, the fraction divide and the interpolation arithmetic.
// ---------------------------------------------------------------------------
module kts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  kts_pkg::status_type   status,
   output kts_pkg::cmd_type      cmd
);

   kts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = kts_pkg::CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         kts_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = kts_pkg::CMD_LATCH;
               state_in = kts_pkg::S_DECODE;
            end
         end
         kts_pkg::S_DECODE: begin
            case (status.op) inside
               kts_pkg::OP_WR_TIME, kts_pkg::OP_WR_VALUE: state_in = kts_pkg::S_WRITE;
               kts_pkg::OP_SAMPLE: state_in = kts_pkg::S_CHECK;
               default:            state_in = kts_pkg::S_IDLE;
            endcase
         end
         kts_pkg::S_WRITE: begin
            cmd      = kts_pkg::CMD_WRITE;
            state_in = kts_pkg::S_IDLE;
         end
         kts_pkg::S_CHECK: begin
            if (status.no_data) begin
               state_in = kts_pkg::S_FALLBACK;
            end else begin
               cmd      = kts_pkg::CMD_RD_FIRST;
               state_in = kts_pkg::S_FIRST;
            end
         end
         kts_pkg::S_FIRST: begin
            cmd      = kts_pkg::CMD_FIRST;
            state_in = status.first_hit ? kts_pkg::S_VAL : kts_pkg::S_LAST;
         end
         kts_pkg::S_LAST: begin
            cmd      = kts_pkg::CMD_LAST;
            state_in = status.last_hit ? kts_pkg::S_VAL : kts_pkg::S_SRCH_A;
         end
         kts_pkg::S_SRCH_A: begin
            if (status.srch_more) begin
               cmd      = kts_pkg::CMD_SRCH_RD;
               state_in = kts_pkg::S_SRCH_B;
            end else begin
               cmd      = kts_pkg::CMD_SRCH_END;
               state_in = kts_pkg::S_SPAN1;
            end
         end
         kts_pkg::S_SRCH_B: begin
            cmd      = kts_pkg::CMD_SRCH_STEP;
            state_in = kts_pkg::S_SRCH_A;
         end
         kts_pkg::S_SPAN1: begin
            cmd      = kts_pkg::CMD_SPAN_RD1;
            state_in = kts_pkg::S_SPAN2;
         end
         kts_pkg::S_SPAN2: begin
            cmd      = kts_pkg::CMD_SPAN_CAP;
            state_in = kts_pkg::S_DIVSET;
         end
         kts_pkg::S_DIVSET: begin
            cmd      = kts_pkg::CMD_DIV_SET;
            state_in = status.div_needed ? kts_pkg::S_DIV : kts_pkg::S_T2;
         end
         kts_pkg::S_DIV: begin
            cmd      = kts_pkg::CMD_DIV_STEP;
            state_in = status.div_last ? kts_pkg::S_T2 : kts_pkg::S_DIV;
         end
         kts_pkg::S_T2: begin
            cmd      = kts_pkg::CMD_T2;
            state_in = kts_pkg::S_T3;
         end
         kts_pkg::S_T3: begin
            cmd      = kts_pkg::CMD_T3;
            state_in = kts_pkg::S_HERM;
         end
         kts_pkg::S_HERM: begin
            cmd      = kts_pkg::CMD_HERM;
            state_in = kts_pkg::S_VAL;
         end
         kts_pkg::S_VAL: begin
            cmd = kts_pkg::CMD_VAL_RD;
            if (status.val_fb) begin
               state_in = kts_pkg::S_FALLBACK;
            end else if (status.val_single) begin
               state_in = kts_pkg::S_SINGLE;
            end else if (status.val_cubic) begin
               state_in = kts_pkg::S_H1;
            end else begin
               state_in = kts_pkg::S_L1;
            end
         end
         kts_pkg::S_SINGLE: begin
            cmd      = kts_pkg::CMD_SINGLE;
            state_in = kts_pkg::S_DONE;
         end
         kts_pkg::S_FALLBACK: begin
            cmd      = kts_pkg::CMD_FALLBACK;
            state_in = kts_pkg::S_DONE;
         end
         kts_pkg::S_L1: begin
            cmd      = kts_pkg::CMD_CAP_A;
            state_in = kts_pkg::S_L2;
         end
         kts_pkg::S_L2: begin
            cmd      = kts_pkg::CMD_CAP_B;
            state_in = kts_pkg::S_LM;
         end
         kts_pkg::S_LM: begin
            cmd      = kts_pkg::CMD_LERP_MUL;
            state_in = kts_pkg::S_LA;
         end
         kts_pkg::S_LA: begin
            cmd      = kts_pkg::CMD_LERP_ADD;
            state_in = status.comp_last ? kts_pkg::S_DONE : kts_pkg::S_LM;
         end
         kts_pkg::S_H1: begin
            cmd      = kts_pkg::CMD_CAP_A;
            state_in = kts_pkg::S_H2;
         end
         kts_pkg::S_H2: begin
            cmd      = kts_pkg::CMD_CAP_B;
            state_in = kts_pkg::S_H3;
         end
         kts_pkg::S_H3: begin
            cmd      = kts_pkg::CMD_CAP_C;
            state_in = kts_pkg::S_H4;
         end
         kts_pkg::S_H4: begin
            cmd      = kts_pkg::CMD_CAP_D;
            state_in = kts_pkg::S_HA;
         end
         kts_pkg::S_HA: begin
            cmd      = kts_pkg::CMD_H_A;
            state_in = kts_pkg::S_HB;
         end
         kts_pkg::S_HB: begin
            cmd      = kts_pkg::CMD_H_B;
            state_in = kts_pkg::S_HC;
         end
         kts_pkg::S_HC: begin
            cmd      = kts_pkg::CMD_H_C;
            state_in = kts_pkg::S_HD;
         end
         kts_pkg::S_HD: begin
            cmd      = kts_pkg::CMD_H_D;
            state_in = kts_pkg::S_HE;
         end
         kts_pkg::S_HE: begin
            cmd      = kts_pkg::CMD_H_E;
            state_in = kts_pkg::S_HF;
         end
         kts_pkg::S_HF: begin
            cmd      = kts_pkg::CMD_H_F;
            state_in = kts_pkg::S_HG;
         end
         kts_pkg::S_HG: begin
            cmd      = kts_pkg::CMD_H_G;
            state_in = status.comp_last ? kts_pkg::S_DONE : kts_pkg::S_HA;
         end
         kts_pkg::S_DONE: begin
            if (status.rsp_free) begin
               cmd      = kts_pkg::CMD_EMIT;
               state_in = kts_pkg::S_IDLE;
            end
         end
         default: state_in = kts_pkg::S_IDLE;
      endcase
   end

endmodule

@@ src/kts_dp.sv @@
// ---------------------------------------------------------------------------
// kts_dp
// Datapath: key time and value memories, configuration registers, search
// bounds, restoring divider, shared multiplier and the result register.
// ---------------------------------------------------------------------------
module kts_dp #(
   parameter int MAX_KEYS  = kts_pkg::MAX_KEYS_DEF,
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kts_pkg::cmd_type                 cmd,
   output kts_pkg::status_type              status,
   input  logic [kts_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [kts_pkg::OP_W-1:0]         req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   input  logic [kts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int VD   = 3 * MAX_KEYS;
   localparam int KAW  = $clog2(MAX_KEYS);
   localparam int VAW  = $clog2(VD);
   localparam int NW   = $clog2(MAX_KEYS + 1);
   localparam int VCW  = $clog2(VD + 1);
   localparam int BW   = $clog2(VD + 2);
   localparam int TW   = FRAC_BITS + 1;
   localparam int HW   = FRAC_BITS + 3;
   localparam int CW   = $clog2(FRAC_BITS + 1);
   localparam int W    = kts_pkg::WORD_W;
   localparam int MW   = kts_pkg::MUL_W;
   localparam int PW   = kts_pkg::PROD_W;
   localparam logic [TW-1:0]        T_ONE = TW'(1) << FRAC_BITS;
   localparam logic signed [HW-1:0] H_ONE = HW'(1) << FRAC_BITS;

   function automatic logic signed [W-1:0] pick(input logic [3*W-1:0] w,
                                                input logic [1:0] c);
      logic signed [W-1:0] r;
      case (c)
         2'd0:    r = w[W-1:0];
         2'd1:    r = w[2*W-1:W];
         default: r = w[3*W-1:2*W];
      endcase
      return r;
   endfunction

   // configuration
   logic [kts_pkg::MODE_W-1:0]   mode_ff;
   logic                         scale_ff;
   logic [kts_pkg::TCOUNT_W-1:0] tcount_ff;
   logic [kts_pkg::VCOUNT_W-1:0] vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= kts_pkg::MODE_RESET;
         scale_ff  <= 1'b0;
         tcount_ff <= '0;
         vcount_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            kts_pkg::CSR_INTERP_MODE:  mode_ff   <= csr_data[kts_pkg::MODE_W-1:0];
            kts_pkg::CSR_SCALE_TARGET: scale_ff  <= csr_data[0];
            kts_pkg::CSR_TIME_COUNT:   tcount_ff <= csr_data[kts_pkg::TCOUNT_W-1:0];
            kts_pkg::CSR_VALUE_COUNT:  vcount_ff <= csr_data[kts_pkg::VCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request transaction
   logic [kts_pkg::REQ_DATA_W-1:0] req_ff;
   logic [kts_pkg::OP_W-1:0]       op_ff;
   logic [NW-1:0]                  n_ff;
   logic [VCW-1:0]                 vc_ff;

   logic [kts_pkg::SLOT_W-1:0] slot;
   logic signed [W-1:0]        tw;
   assign slot = req_ff[9:0];
   assign tw   = req_ff[41:10];

   always_ff @(posedge clock) begin
      if (cmd == kts_pkg::CMD_LATCH) begin
         req_ff <= req_tdata;
         op_ff  <= req_tuser;
         n_ff   <= (32'(tcount_ff) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(tcount_ff);
         vc_ff  <= (32'(vcount_ff) > 32'(VD)) ? VCW'(VD) : VCW'(vcount_ff);
      end
   end

   // memories
   logic [W-1:0]   key_mem [MAX_KEYS];
   logic [3*W-1:0] val_mem [VD];
   logic signed [W-1:0] key_q_ff;
   logic [3*W-1:0]      val_q_ff;
   logic [KAW-1:0]      key_addr;
   logic [VAW-1:0]      val_addr;

   always_ff @(posedge clock) begin
      if (cmd == kts_pkg::CMD_WRITE && op_ff == kts_pkg::OP_WR_TIME &&
          32'(slot) < 32'(MAX_KEYS)) begin
         key_mem[KAW'(slot)] <= tw;
      end
      key_q_ff <= key_mem[key_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd == kts_pkg::CMD_WRITE && op_ff == kts_pkg::OP_WR_VALUE &&
          32'(slot) < 32'(VD)) begin
         val_mem[VAW'(slot)] <= req_ff[137:42];
      end
      val_q_ff <= val_mem[val_addr];
   end

   // span search
   logic [NW-1:0]  lo_ff, hi_ff, mid, lo_m1, n_m2, idx_clamp;
   logic [KAW-1:0] idx_ff;
   logic [NW:0]    mid_sum;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[NW:1];
   assign lo_m1     = (lo_ff == '0) ? '0 : lo_ff - NW'(1);
   assign n_m2      = n_ff - NW'(2);
   assign idx_clamp = (lo_m1 > n_m2) ? n_m2 : lo_m1;

   always_comb begin
      key_addr = '0;
      case (cmd)
         kts_pkg::CMD_FIRST:    key_addr = KAW'(n_ff - NW'(1));
         kts_pkg::CMD_SRCH_RD:  key_addr = KAW'(mid);
         kts_pkg::CMD_SRCH_END: key_addr = KAW'(idx_clamp);
         kts_pkg::CMD_SPAN_RD1: key_addr = idx_ff + KAW'(1);
         default:               key_addr = '0;
      endcase
   end

   // fraction divide
   logic signed [W-1:0] k0_ff;
   logic signed [W:0]   num_ff, span_ff;
   logic [W+1:0]        rem_ff, rem_sh, span_u;
   logic [FRAC_BITS-1:0] q_ff, q_next;
   logic [CW-1:0]        cnt_ff;
   logic [TW-1:0]        t_ff, t2_ff, t3;
   logic                 qbit;

   assign span_u = {1'b0, span_ff};
   assign rem_sh = {rem_ff[W:0], 1'b0};
   assign qbit   = rem_sh >= span_u;
   assign q_next = {q_ff[FRAC_BITS-2:0], qbit};
   assign t3     = p_ff[FRAC_BITS +: TW];

   // shared multiplier
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] p_ff, acc_ff, p_f, p_16;
   logic signed [HW-1:0] h00_ff, h10_ff, h01_ff, h11_ff;
   logic signed [HW-1:0] t2s, t3s, ts;
   logic [3*W-1:0]       va_ff, vb_ff, vm_ff, vd_ff;
   logic [1:0]           c_ff;
   logic signed [W-1:0]  va_c, vb_c, vm_c, vd_c;
   logic signed [MW-1:0] t_m;

   assign p_f  = p_ff >>> FRAC_BITS;
   assign p_16 = p_ff >>> 16;
   assign va_c = pick(va_ff, c_ff);
   assign vb_c = pick(vb_ff, c_ff);
   assign vm_c = pick(vm_ff, c_ff);
   assign vd_c = pick(vd_ff, c_ff);
   assign t_m  = $signed({{(MW-TW){1'b0}}, t_ff});
   assign t2s  = $signed({2'b00, t2_ff});
   assign t3s  = $signed({2'b00, t3});
   assign ts   = $signed({2'b00, t_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd)
         kts_pkg::CMD_T2: begin
            mul_a = t_m;
            mul_b = t_m;
         end
         kts_pkg::CMD_T3: begin
            mul_a = $signed({{(MW-TW){1'b0}}, p_ff[FRAC_BITS +: TW]});
            mul_b = t_m;
         end
         kts_pkg::CMD_LERP_MUL: begin
            mul_a = MW'(vb_c) - MW'(va_c);
            mul_b = t_m;
         end
         kts_pkg::CMD_H_A: begin
            mul_a = MW'(va_c);
            mul_b = MW'(h00_ff);
         end
         kts_pkg::CMD_H_B: begin
            mul_a = MW'(vd_c);
            mul_b = MW'(h01_ff);
         end
         kts_pkg::CMD_H_C: begin
            mul_a = MW'(vb_c);
            mul_b = MW'(h10_ff);
         end
         kts_pkg::CMD_H_E: begin
            mul_a = MW'(vm_c);
            mul_b = MW'(h11_ff);
         end
         kts_pkg::CMD_H_D, kts_pkg::CMD_H_F: begin
            mul_a = MW'(p_f);
            mul_b = MW'(span_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
   end

   // value path selection
   logic          cubic;
   logic [BW-1:0] base, idx_b;
   assign cubic = mode_ff == kts_pkg::MODE_CUBIC;
   assign idx_b = BW'(idx_ff);
   assign base  = idx_b * BW'(3);

   always_comb begin
      val_addr = '0;
      case (cmd)
         kts_pkg::CMD_VAL_RD: val_addr = cubic ? VAW'(base + BW'(1)) : VAW'(idx_b);
         kts_pkg::CMD_CAP_A:  val_addr = cubic ? VAW'(base + BW'(2))
                                               : VAW'(idx_b + BW'(1));
         kts_pkg::CMD_CAP_B:  val_addr = VAW'(base + BW'(3));
         kts_pkg::CMD_CAP_C:  val_addr = VAW'(base + BW'(4));
         default:             val_addr = '0;
      endcase
   end

   // result
   logic [W-1:0] res_ff [3];
   logic         fb_ff;
   logic [W-1:0] neutral;
   logic [RSP_W_DUMMY:0] unused_none;
   localparam int RSP_W_DUMMY = 0;
   assign unused_none = 1'b0;
   assign neutral = scale_ff ? kts_pkg::NEUTRAL_ONE : '0;

   always_ff @(posedge clock) begin
      case (cmd)
         kts_pkg::CMD_FIRST: begin
            idx_ff <= '0;
            t_ff   <= '0;
         end
         kts_pkg::CMD_LAST: begin
            idx_ff <= KAW'(n_ff - NW'(1));
            t_ff   <= '0;
            lo_ff  <= '0;
            hi_ff  <= n_ff;
         end
         kts_pkg::CMD_SRCH_STEP: begin
            if (key_q_ff <= tw) begin
               lo_ff <= mid + NW'(1);
            end else begin
               hi_ff <= mid;
            end
         end
         kts_pkg::CMD_SRCH_END: idx_ff <= KAW'(idx_clamp);
         kts_pkg::CMD_SPAN_RD1: k0_ff <= key_q_ff;
         kts_pkg::CMD_SPAN_CAP: begin
            num_ff  <= (W+1)'(tw) - (W+1)'(k0_ff);
            span_ff <= (W+1)'(key_q_ff) - (W+1)'(k0_ff);
         end
         kts_pkg::CMD_DIV_SET: begin
            if (span_ff <= 0 || num_ff <= 0) begin
               t_ff <= '0;
            end else if (num_ff >= span_ff) begin
               t_ff <= T_ONE;
            end else begin
               t_ff <= '0;
            end
            rem_ff <= (W+2)'(num_ff[W-1:0]);
            q_ff   <= '0;
            cnt_ff <= CW'(FRAC_BITS);
         end
         kts_pkg::CMD_DIV_STEP: begin
            rem_ff <= qbit ? rem_sh - span_u : rem_sh;
            q_ff   <= q_next;
            t_ff   <= {1'b0, q_next};
            cnt_ff <= cnt_ff - CW'(1);
         end
         kts_pkg::CMD_T3: t2_ff <= p_ff[FRAC_BITS +: TW];
         kts_pkg::CMD_HERM: begin
            h00_ff <= (t3s <<< 1) - (t2s + (t2s <<< 1)) + H_ONE;
            h10_ff <= t3s - (t2s <<< 1) + ts;
            h01_ff <= (t2s + (t2s <<< 1)) - (t3s <<< 1);
            h11_ff <= t3s - t2s;
         end
         kts_pkg::CMD_VAL_RD: c_ff <= '0;
         kts_pkg::CMD_SINGLE: begin
            res_ff[0] <= val_q_ff[W-1:0];
            res_ff[1] <= val_q_ff[2*W-1:W];
            res_ff[2] <= val_q_ff[3*W-1:2*W];
            fb_ff     <= 1'b0;
         end
         kts_pkg::CMD_FALLBACK: begin
            res_ff[0] <= neutral;
            res_ff[1] <= neutral;
            res_ff[2] <= neutral;
            fb_ff     <= 1'b1;
         end
         kts_pkg::CMD_CAP_A: va_ff <= val_q_ff;
         kts_pkg::CMD_CAP_B: vb_ff <= val_q_ff;
         kts_pkg::CMD_CAP_C: vm_ff <= val_q_ff;
         kts_pkg::CMD_CAP_D: vd_ff <= val_q_ff;
         kts_pkg::CMD_LERP_ADD: begin
            res_ff[c_ff] <= kts_pkg::sat_word(PW'(va_c) + p_f);
            fb_ff        <= 1'b0;
            c_ff         <= c_ff + 2'd1;
         end
         kts_pkg::CMD_H_B: acc_ff <= p_ff;
         kts_pkg::CMD_H_C: acc_ff <= (acc_ff + p_ff) >>> FRAC_BITS;
         kts_pkg::CMD_H_E: acc_ff <= acc_ff + p_16;
         kts_pkg::CMD_H_G: begin
            res_ff[c_ff] <= kts_pkg::sat_word(acc_ff + p_16);
            fb_ff        <= 1'b0;
            c_ff         <= c_ff + 2'd1;
         end
         default: ;
      endcase
   end

   // output register
   logic                          rsp_tvalid_ff;
   logic [kts_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                          rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd == kts_pkg::CMD_EMIT) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == kts_pkg::CMD_EMIT) begin
         rsp_tdata_ff <= {res_ff[2], res_ff[1], res_ff[0]};
         rsp_tuser_ff <= fb_ff | unused_none[0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // status
   always_comb begin
      status            = '0;
      status.op         = op_ff;
      status.no_data    = (n_ff == '0) || (vc_ff == '0);
      status.first_hit  = (n_ff < NW'(2)) || (tw <= key_q_ff);
      status.last_hit   = tw >= key_q_ff;
      status.srch_more  = lo_ff < hi_ff;
      status.div_needed = (span_ff > 0) && (num_ff > 0) && (num_ff < span_ff);
      status.div_last   = cnt_ff == CW'(1);
      status.val_cubic  = cubic;
      status.val_fb     = cubic ? (base + BW'(1) >= BW'(vc_ff)) : (idx_b >= BW'(vc_ff));
      status.val_single = cubic ? ((t_ff == '0) || (base + BW'(4) >= BW'(vc_ff)))
                                : ((mode_ff == kts_pkg::MODE_STEP) || (t_ff == '0) ||
                                   (idx_b + BW'(1) >= BW'(vc_ff)));
      status.comp_last  = c_ff == 2'd2;
      status.rsp_free   = !rsp_tvalid_ff || rsp_tready;
   end

   a_fallback_neutral: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff |-> rsp_tdata_ff == {neutral, neutral, neutral})
      else $error("fallback result is not the neutral value");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      cmd == kts_pkg::CMD_HERM |-> t_ff <= T_ONE)
      else $error("span fraction above one");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd == kts_pkg::CMD_EMIT |=> rsp_tvalid_ff)
      else $error("emitted result not presented");

endmodule
